/* rtl/itfc_pkg.sv */
// ----------------------------------------------------------------------------
// IPv4/TCP frame classifier package
// Shared constants and the verdict type for the frame classifier.
// ----------------------------------------------------------------------------
package itfc_pkg;

   localparam int COUNTER_BITS_DEFAULT = 32;
   localparam int OUT_COUNT_BITS       = 32;

   localparam logic [15:0] POS_MAX         = 16'hFFFF;
   localparam logic [15:0] POS_ETYPE_HI    = 16'd12;
   localparam logic [15:0] POS_ETYPE_LO    = 16'd13;
   localparam logic [15:0] POS_VER_IHL     = 16'd14;
   localparam logic [15:0] POS_TLEN_HI     = 16'd16;
   localparam logic [15:0] POS_TLEN_LO     = 16'd17;
   localparam logic [15:0] POS_PROTOCOL    = 16'd23;
   localparam logic [6:0]  TCP_OFFSET_BASE = 7'd26;

   localparam logic [7:0]  ETH_HDR_BYTES   = 8'd14;
   localparam logic [6:0]  MIN_HDR_BYTES   = 7'd20;
   localparam logic [16:0] MIN_FRAME_BYTES = 17'd34;
   localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
   localparam logic [3:0]  IP_VERSION_4    = 4'd4;
   localparam logic [7:0]  PROTO_TCP       = 8'd6;

   typedef enum logic [1:0] {
      VERDICT_TCP    = 2'd0,
      VERDICT_OTHER  = 2'd1,
      VERDICT_NOT_IP = 2'd2,
      VERDICT_BAD    = 2'd3
   } verdict_type;

endpackage

/* rtl/ipv4_tcp_frame_classifier.sv */
// ----------------------------------------------------------------------------
// IPv4/TCP frame classifier
// Classifies Ethernet frames byte by byte and reports one verdict per frame.
// ----------------------------------------------------------------------------
// Usage:
// Frame bytes enter on the req_ channel, one byte per transfer, starting at
// the destination address, with req_frame_last set on the final byte. Each
// transfer lands in an input register; from there the header fields are
// captured and, on the final byte, the verdict is formed and written to the
// result register, which drives the rsp_ channel. One result leaves per frame.
// Throughput is one byte per cycle while no last byte is held back. The last
// byte passes the input register, then the result register, to rsp_valid. The
// frame counters on rsp_ show the totals including the frame being reported.
// When the receiver stalls with a result pending, the block still accepts
// the following bytes of the next frame; only a further last byte waits in
// the input register until the result register frees, and req_ready then
// drops. Synchronous reset clears all frame state, the counters and both
// valid flags.
// ----------------------------------------------------------------------------
module ipv4_tcp_frame_classifier #(
   parameter int COUNTER_BITS = itfc_pkg::COUNTER_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_verdict,
   output logic [7:0]  rsp_proto_number,
   output logic        rsp_has_payload,
   output logic [7:0]  rsp_payload_offset,
   output logic [15:0] rsp_payload_length,
   output logic [31:0] rsp_frames_seen,
   output logic [31:0] rsp_frames_malformed,
   output logic [31:0] rsp_frames_tcp
);

   // Input register.
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;

   // Per-frame capture state.
   logic [15:0] pos_ff, pos_in;
   logic [15:0] etype_ff, etype_in;
   logic [3:0]  ver_ff, ver_in;
   logic [3:0]  ihl_ff, ihl_in;
   logic [15:0] tlen_ff, tlen_in;
   logic [7:0]  proto_ff, proto_in;
   logic [3:0]  tcpw_ff, tcpw_in;

   // Wrapping counters.
   logic [COUNTER_BITS-1:0] seen_ff, seen_in;
   logic [COUNTER_BITS-1:0] bad_ff, bad_in;
   logic [COUNTER_BITS-1:0] tcp_ff, tcp_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   itfc_pkg::verdict_type verdict_ff, verdict_in;
   logic [7:0]            rproto_ff, rproto_in;
   logic [7:0]            off_ff, off_in;
   logic [15:0]           plen_ff, plen_in;

   logic        out_free;
   logic        proc_fire;
   logic        load_rsp;
   logic [6:0]  tcp_pos;
   logic [6:0]  hlen;
   logic [6:0]  tcplen;
   logic [6:0]  hdrs_len;
   logic [16:0] frame_len;
   logic [16:0] tlen_eth;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign proc_fire = in_valid_ff && (!in_last_ff || out_free);
   assign load_rsp  = proc_fire && in_last_ff;
   assign req_ready = !in_valid_ff || proc_fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_frame_last;
      end
   end

   // Capture of the header fields at their fixed byte positions. The TCP
   // offset position follows from the header length held before this byte.
   assign tcp_pos = itfc_pkg::TCP_OFFSET_BASE + {1'b0, ihl_ff, 2'b00};

   always_comb begin
      etype_in = etype_ff;
      ver_in   = ver_ff;
      ihl_in   = ihl_ff;
      tlen_in  = tlen_ff;
      proto_in = proto_ff;
      tcpw_in  = tcpw_ff;
      if (pos_ff == itfc_pkg::POS_ETYPE_HI) begin
         etype_in[15:8] = in_byte_ff;
      end
      if (pos_ff == itfc_pkg::POS_ETYPE_LO) begin
         etype_in[7:0] = in_byte_ff;
      end
      if (pos_ff == itfc_pkg::POS_VER_IHL) begin
         ver_in = in_byte_ff[7:4];
         ihl_in = in_byte_ff[3:0];
      end
      if (pos_ff == itfc_pkg::POS_TLEN_HI) begin
         tlen_in[15:8] = in_byte_ff;
      end
      if (pos_ff == itfc_pkg::POS_TLEN_LO) begin
         tlen_in[7:0] = in_byte_ff;
      end
      if (pos_ff == itfc_pkg::POS_PROTOCOL) begin
         proto_in = in_byte_ff;
      end
      if (pos_ff == {9'd0, tcp_pos}) begin
         tcpw_in = in_byte_ff[7:4];
      end
   end

   // Verdict, formed from the values as they stand after this byte's capture.
   assign hlen      = {1'b0, ihl_in, 2'b00};
   assign tcplen    = {1'b0, tcpw_in, 2'b00};
   assign hdrs_len  = hlen + tcplen;
   assign frame_len = {1'b0, pos_ff} + 17'd1;
   assign tlen_eth  = {1'b0, tlen_in} + {9'd0, itfc_pkg::ETH_HDR_BYTES};

   always_comb begin
      verdict_in = itfc_pkg::VERDICT_NOT_IP;
      rproto_in  = 8'd0;
      plen_in    = 16'd0;
      off_in     = 8'd0;
      if (frame_len < itfc_pkg::MIN_FRAME_BYTES || etype_in != itfc_pkg::ETHERTYPE_IPV4
          || ver_in != itfc_pkg::IP_VERSION_4) begin
         verdict_in = itfc_pkg::VERDICT_NOT_IP;
      end else if (hlen < itfc_pkg::MIN_HDR_BYTES || tlen_in < {9'd0, hlen}
                   || tlen_eth > frame_len) begin
         verdict_in = itfc_pkg::VERDICT_BAD;
      end else if (proto_in != itfc_pkg::PROTO_TCP) begin
         verdict_in = itfc_pkg::VERDICT_OTHER;
         rproto_in  = proto_in;
         plen_in    = tlen_in - {9'd0, hlen};
         off_in     = itfc_pkg::ETH_HDR_BYTES + {1'b0, hlen};
      end else if (tlen_in < {9'd0, hlen} + {9'd0, itfc_pkg::MIN_HDR_BYTES}
                   || tcplen < itfc_pkg::MIN_HDR_BYTES || tlen_in < {9'd0, hdrs_len}) begin
         verdict_in = itfc_pkg::VERDICT_BAD;
      end else begin
         verdict_in = itfc_pkg::VERDICT_TCP;
         rproto_in  = proto_in;
         plen_in    = tlen_in - {9'd0, hdrs_len};
         off_in     = itfc_pkg::ETH_HDR_BYTES + {1'b0, hdrs_len};
      end
      // An empty payload reports no offset.
      if (plen_in == 16'd0) begin
         off_in = 8'd0;
      end
   end

   always_comb begin
      pos_in  = pos_ff;
      seen_in = seen_ff;
      bad_in  = bad_ff;
      tcp_in  = tcp_ff;
      if (proc_fire) begin
         if (in_last_ff) begin
            pos_in  = 16'd0;
            seen_in = seen_ff + 1'b1;
            if (verdict_in == itfc_pkg::VERDICT_BAD) begin
               bad_in = bad_ff + 1'b1;
            end
            if (verdict_in == itfc_pkg::VERDICT_TCP) begin
               tcp_in = tcp_ff + 1'b1;
            end
         end else if (pos_ff != itfc_pkg::POS_MAX) begin
            pos_in = pos_ff + 16'd1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 16'd0;
         etype_ff     <= 16'd0;
         ver_ff       <= 4'd0;
         ihl_ff       <= 4'd0;
         tlen_ff      <= 16'd0;
         proto_ff     <= 8'd0;
         tcpw_ff      <= 4'd0;
         seen_ff      <= '0;
         bad_ff       <= '0;
         tcp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         seen_ff      <= seen_in;
         bad_ff       <= bad_in;
         tcp_ff       <= tcp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (proc_fire) begin
            if (in_last_ff) begin
               etype_ff <= 16'd0;
               ver_ff   <= 4'd0;
               ihl_ff   <= 4'd0;
               tlen_ff  <= 16'd0;
               proto_ff <= 8'd0;
               tcpw_ff  <= 4'd0;
            end else begin
               etype_ff <= etype_in;
               ver_ff   <= ver_in;
               ihl_ff   <= ihl_in;
               tlen_ff  <= tlen_in;
               proto_ff <= proto_in;
               tcpw_ff  <= tcpw_in;
            end
         end
      end
      if (load_rsp) begin
         verdict_ff <= verdict_in;
         rproto_ff  <= rproto_in;
         off_ff     <= off_in;
         plen_ff    <= plen_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_verdict        = verdict_ff;
   assign rsp_proto_number   = rproto_ff;
   assign rsp_has_payload    = (plen_ff != 16'd0);
   assign rsp_payload_offset = off_ff;
   assign rsp_payload_length = plen_ff;

   // The counters change only when a result is loaded, so they always match
   // the result being shown.
   generate
      if (COUNTER_BITS >= itfc_pkg::OUT_COUNT_BITS) begin : g_cnt_wide
         assign rsp_frames_seen      = seen_ff[itfc_pkg::OUT_COUNT_BITS-1:0];
         assign rsp_frames_malformed = bad_ff[itfc_pkg::OUT_COUNT_BITS-1:0];
         assign rsp_frames_tcp       = tcp_ff[itfc_pkg::OUT_COUNT_BITS-1:0];
      end else begin : g_cnt_narrow
         assign rsp_frames_seen      =
            {{(itfc_pkg::OUT_COUNT_BITS-COUNTER_BITS){1'b0}}, seen_ff};
         assign rsp_frames_malformed =
            {{(itfc_pkg::OUT_COUNT_BITS-COUNTER_BITS){1'b0}}, bad_ff};
         assign rsp_frames_tcp       =
            {{(itfc_pkg::OUT_COUNT_BITS-COUNTER_BITS){1'b0}}, tcp_ff};
      end
   endgenerate

`ifndef SYNTHESIS
   a_rejected_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (verdict_ff == itfc_pkg::VERDICT_NOT_IP
                       || verdict_ff == itfc_pkg::VERDICT_BAD)
      |-> rproto_ff == 8'd0 && plen_ff == 16'd0 && off_ff == 8'd0)
      else $error("rejected frame carries protocol or payload fields");

   a_empty_no_offset : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && plen_ff == 16'd0 |-> off_ff == 8'd0)
      else $error("empty payload reported with an offset");

   a_tcp_count : assert property (@(posedge clock) disable iff (reset)
      load_rsp && verdict_in == itfc_pkg::VERDICT_TCP
      |=> tcp_ff == $past(tcp_ff) + 1'b1)
      else $error("TCP counter did not advance on a TCP verdict");

   a_pos_restart : assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> pos_ff == 16'd0 && tlen_ff == 16'd0)
      else $error("frame state not cleared after the last byte");
`endif

endmodule
